// ===== src/max_flow_bfs_augment_core_assert.svh =====
// Assertion macros for the max-flow core.
// Used by the top level only; empty bodies when SYNTHESIS is defined.
`ifndef MAX_FLOW_BFS_AUGMENT_CORE_ASSERT_SVH
`define MAX_FLOW_BFS_AUGMENT_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define MFB_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define MFB_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define MFB_ASSERT(lbl, clk, rstn, prop, msg)
`define MFB_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== src/mfb_pkg.sv =====
// Shared types and constants of the max-flow core.
// No dependencies.
`timescale 1ns / 1ps
package mfb_pkg;
    localparam int MAX_NODES = 64;
    localparam int NODE_W    = 6;
    localparam int CNT_W     = 7;
    localparam int CAP_BITS  = 32;
    localparam int FLOW_W    = 40;
    localparam int PATH_W    = 16;
    localparam int ADDR_W    = 12;
    localparam int MAT_DEPTH = 4096;
    localparam logic [FLOW_W-1:0] FLOW_MAX = '1;
    localparam logic [PATH_W-1:0] PATH_MAX = '1;
    localparam logic REQ_WRITE   = 1'b0;
    localparam logic REQ_COMPUTE = 1'b1;

    typedef struct packed {
        logic                req_type;
        logic [NODE_W-1:0]   from_node;
        logic [NODE_W-1:0]   to_node;
        logic [CAP_BITS-1:0] capacity;
    } t_in;

    typedef struct packed {
        logic [FLOW_W-1:0] max_flow;
        logic [PATH_W-1:0] path_count;
    } t_out;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_COPY, S_BFS_INIT, S_POP, S_POP_WAIT, S_SCAN,
        S_AUG_P, S_AUG_R, S_AUG_M, S_UPD_P, S_UPD_R, S_UPD_F, S_UPD_B,
        S_ACC, S_DONE
    } t_state;
endpackage

// ===== src/mfb_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module mfb_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/max_flow_bfs_augment_core.sv =====
// Edmonds-Karp max-flow core: sequencer around capacity, residual, parent and queue RAMs.
// Depends on mfb_pkg, mfb_ram and max_flow_bfs_augment_core_assert.svh.
//
// Usage:
//   Request channel (i_valid/o_ready, i_req): req_type 0 stores one edge capacity;
//   req_type 1 computes the max flow from node 0 to node node_count-1.
//   Response channel (o_valid/i_ready, o_rsp): one response per compute request,
//   with the total flow (saturating, 40 bits) and the number of augmenting paths.
//   Config: i_cfg_we/i_cfg_wdata writes node_count (saturated to 2..64 on use).
// Sequence:
//   After reset a clearing pass zeroes the capacity RAM; no request is accepted
//   during it. A compute copies the full 4096-entry matrix into the residual RAM,
//   then runs searches from node 0 (a search stops early once the sink is seen)
//   and, for each path found, walks the parent chain once for the bottleneck and
//   once for the update. After the last, failed search the response is loaded into
//   the output register. All of this is paced by the single read port of the residual RAM.
//   Edge writes go at one per cycle while the core is idle.
// Stall: the response sits in an output register; edge writes are still taken while
//   it waits, a following compute finishes but holds until the response is taken.
`timescale 1ns / 1ps
`include "max_flow_bfs_augment_core_assert.svh"
module max_flow_bfs_augment_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  mfb_pkg::t_in i_req,
    output logic         o_valid,
    input  logic         i_ready,
    output mfb_pkg::t_out o_rsp,
    input  logic         i_cfg_we,
    input  logic [6:0]   i_cfg_wdata
);
    import mfb_pkg::*;

    t_state r_state, n_state;
    logic [CNT_W-1:0]  r_node_count;
    logic [CNT_W-1:0]  r_n, n_n;
    logic [NODE_W-1:0] r_sink, n_sink;
    logic [ADDR_W:0]   r_cnt, n_cnt;
    logic              r_cw_valid, n_cw_valid;
    logic [ADDR_W-1:0] r_cw_addr, n_cw_addr;
    logic [MAX_NODES-1:0] r_visited, n_visited;
    logic [CNT_W-1:0]  r_head, n_head, r_tail, n_tail;
    logic [NODE_W-1:0] r_x, n_x;
    logic [CNT_W-1:0]  r_issue, n_issue;
    logic              r_pend, n_pend;
    logic [NODE_W-1:0] r_pend_v, n_pend_v;
    logic [NODE_W-1:0] r_v, n_v, r_u, n_u;
    logic [FLOW_W-1:0] r_bn, n_bn, r_flow, n_flow;
    logic [PATH_W-1:0] r_paths, n_paths;
    logic              r_out_valid, n_out_valid;
    t_out              r_out, n_out;

    logic              cap_we;
    logic [ADDR_W-1:0] cap_waddr, cap_raddr;
    logic [CAP_BITS-1:0] cap_wdata, cap_rdata;
    logic              res_we;
    logic [ADDR_W-1:0] res_waddr, res_raddr;
    logic [FLOW_W-1:0] res_wdata, res_rdata;
    logic              par_we;
    logic [NODE_W-1:0] par_waddr, par_wdata, par_raddr, par_rdata;
    logic              q_we;
    logic [NODE_W-1:0] q_waddr, q_wdata, q_raddr, q_rdata;
    logic [FLOW_W:0]   flow_sum;

    mfb_ram #(.DEPTH(MAT_DEPTH), .WIDTH(CAP_BITS)) u_cap (
        .i_clk, .i_we(cap_we), .i_waddr(cap_waddr), .i_wdata(cap_wdata),
        .i_raddr(cap_raddr), .o_rdata(cap_rdata));
    mfb_ram #(.DEPTH(MAT_DEPTH), .WIDTH(FLOW_W)) u_res (
        .i_clk, .i_we(res_we), .i_waddr(res_waddr), .i_wdata(res_wdata),
        .i_raddr(res_raddr), .o_rdata(res_rdata));
    mfb_ram #(.DEPTH(MAX_NODES), .WIDTH(NODE_W)) u_par (
        .i_clk, .i_we(par_we), .i_waddr(par_waddr), .i_wdata(par_wdata),
        .i_raddr(par_raddr), .o_rdata(par_rdata));
    mfb_ram #(.DEPTH(MAX_NODES), .WIDTH(NODE_W)) u_q (
        .i_clk, .i_we(q_we), .i_waddr(q_waddr), .i_wdata(q_wdata),
        .i_raddr(q_raddr), .o_rdata(q_rdata));

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_rsp    = r_out;
    assign flow_sum = {1'b0, r_flow} + {1'b0, r_bn};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_node_count <= CNT_W'(MAX_NODES);
            r_cnt        <= '0;
            r_cw_valid   <= 1'b0;
            r_visited    <= '0;
            r_pend       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_flow       <= '0;
            r_paths      <= '0;
            r_head       <= '0;
            r_tail       <= '0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_cw_valid  <= n_cw_valid;
            r_visited   <= n_visited;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            r_flow      <= n_flow;
            r_paths     <= n_paths;
            r_head      <= n_head;
            r_tail      <= n_tail;
            if (i_cfg_we) begin
                r_node_count <= i_cfg_wdata;
            end
        end
        r_n      <= n_n;
        r_sink   <= n_sink;
        r_cw_addr <= n_cw_addr;
        r_x      <= n_x;
        r_issue  <= n_issue;
        r_pend_v <= n_pend_v;
        r_v      <= n_v;
        r_u      <= n_u;
        r_bn     <= n_bn;
        r_out    <= n_out;
    end

    always_comb begin
        n_state = r_state;
        n_n = r_n;
        n_sink = r_sink;
        n_cnt = r_cnt;
        n_cw_valid = 1'b0;
        n_cw_addr = r_cnt[ADDR_W-1:0];
        n_visited = r_visited;
        n_head = r_head;
        n_tail = r_tail;
        n_x = r_x;
        n_issue = r_issue;
        n_pend = 1'b0;
        n_pend_v = r_issue[NODE_W-1:0];
        n_v = r_v;
        n_u = r_u;
        n_bn = r_bn;
        n_flow = r_flow;
        n_paths = r_paths;
        n_out = r_out;
        n_out_valid = r_out_valid && !i_ready;
        cap_we = 1'b0;
        cap_waddr = r_cnt[ADDR_W-1:0];
        cap_wdata = '0;
        cap_raddr = r_cnt[ADDR_W-1:0];
        res_we = 1'b0;
        res_waddr = r_cw_addr;
        res_wdata = {{(FLOW_W-CAP_BITS){1'b0}}, cap_rdata};
        res_raddr = {r_x, r_issue[NODE_W-1:0]};
        par_we = 1'b0;
        par_waddr = r_pend_v;
        par_wdata = r_x;
        par_raddr = r_v;
        q_we = 1'b0;
        q_waddr = r_tail[NODE_W-1:0];
        q_wdata = r_pend_v;
        q_raddr = r_head[NODE_W-1:0];
        unique case (r_state)
            S_CLEAR: begin
                cap_we = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == (ADDR_W+1)'(MAT_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    if (i_req.req_type == REQ_WRITE) begin
                        cap_we    = 1'b1;
                        cap_waddr = {i_req.from_node, i_req.to_node};
                        cap_wdata = i_req.capacity;
                    end else begin
                        if (r_node_count < CNT_W'(2)) begin
                            n_n = CNT_W'(2);
                        end else if (r_node_count > CNT_W'(MAX_NODES)) begin
                            n_n = CNT_W'(MAX_NODES);
                        end else begin
                            n_n = r_node_count;
                        end
                        n_sink  = NODE_W'(n_n - 1'b1);
                        n_cnt   = '0;
                        n_flow  = '0;
                        n_paths = '0;
                        n_state = S_COPY;
                    end
                end
            end
            S_COPY: begin
                // read capacity now, write residual in the next cycle
                res_we = r_cw_valid;
                if (r_cnt != (ADDR_W+1)'(MAT_DEPTH)) begin
                    n_cw_valid = 1'b1;
                    n_cnt = r_cnt + 1'b1;
                end else if (!r_cw_valid) begin
                    n_state = S_BFS_INIT;
                end
            end
            S_BFS_INIT: begin
                n_visited = '0;
                n_visited[0] = 1'b1;
                q_we = 1'b1;
                q_waddr = '0;
                q_wdata = '0;
                n_head = '0;
                n_tail = CNT_W'(1);
                n_state = S_POP;
            end
            S_POP: begin
                if (r_head == r_tail) begin
                    n_state = S_DONE;
                end else begin
                    n_head = r_head + 1'b1;
                    n_state = S_POP_WAIT;
                end
            end
            S_POP_WAIT: begin
                n_x = q_rdata;
                n_issue = '0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_pend && !r_visited[r_pend_v] && (res_rdata != '0)) begin
                    n_visited[r_pend_v] = 1'b1;
                    par_we = 1'b1;
                    if (r_pend_v == r_sink) begin
                        n_v = r_sink;
                        n_bn = FLOW_MAX;
                        n_state = S_AUG_P;
                    end else if (r_tail < CNT_W'(MAX_NODES)) begin
                        q_we = 1'b1;
                        n_tail = r_tail + 1'b1;
                    end
                end
                if (n_state == S_SCAN) begin
                    if (r_issue < r_n) begin
                        n_pend = 1'b1;
                        n_issue = r_issue + 1'b1;
                    end else if (!r_pend) begin
                        n_state = S_POP;
                    end
                end
            end
            S_AUG_P: begin
                n_state = S_AUG_R;
            end
            S_AUG_R: begin
                n_u = par_rdata;
                res_raddr = {par_rdata, r_v};
                n_state = S_AUG_M;
            end
            S_AUG_M: begin
                if (res_rdata < r_bn) begin
                    n_bn = res_rdata;
                end
                if (r_u == '0) begin
                    n_v = r_sink;
                    n_state = S_UPD_P;
                end else begin
                    n_v = r_u;
                    n_state = S_AUG_P;
                end
            end
            S_UPD_P: begin
                n_state = S_UPD_R;
            end
            S_UPD_R: begin
                n_u = par_rdata;
                res_raddr = {par_rdata, r_v};
                n_state = S_UPD_F;
            end
            S_UPD_F: begin
                res_we = 1'b1;
                res_waddr = {r_u, r_v};
                res_wdata = res_rdata - r_bn;
                res_raddr = {r_v, r_u};
                n_state = S_UPD_B;
            end
            S_UPD_B: begin
                res_we = 1'b1;
                res_waddr = {r_v, r_u};
                res_wdata = res_rdata + r_bn;
                n_v = r_u;
                n_state = (r_u == '0) ? S_ACC : S_UPD_P;
            end
            S_ACC: begin
                n_flow = flow_sum[FLOW_W] ? FLOW_MAX : flow_sum[FLOW_W-1:0];
                if (r_paths != PATH_MAX) begin
                    n_paths = r_paths + 1'b1;
                end
                n_state = S_BFS_INIT;
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out.max_flow = r_flow;
                    n_out.path_count = r_paths;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `MFB_ASSERT(a_head_le_tail, i_clk, i_rst_n, (r_head <= r_tail), "queue head past tail")
    `MFB_ASSERT(a_tail_bound, i_clk, i_rst_n, (r_tail <= CNT_W'(MAX_NODES)), "queue overflow")
    `MFB_ASSERT_IMP(a_no_res_wr_idle, i_clk, i_rst_n, (r_state == S_IDLE), !res_we,
                    "residual write while idle")
    `MFB_ASSERT_IMP(a_src_visited, i_clk, i_rst_n, (r_state == S_SCAN), r_visited[0],
                    "source not marked in search")
endmodule

// ===== dv/max_flow_bfs_augment_core_tb.sv =====
// Self-checking testbench for max_flow_bfs_augment_core: directed table, then random graphs.
// Depends on mfb_pkg and the core RTL; results are predicted by an Edmonds-Karp model below.
`timescale 1ns / 1ps
module max_flow_bfs_augment_core_tb;
    import mfb_pkg::*;

    localparam int  NUM_ITEMS   = 1900;
    localparam int  CYCLE_LIMIT = 100000000;
    localparam int  SETTLE      = 32;

    typedef enum logic {ROW_REQ, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind kind;
        t_in       req;
        logic [6:0] cfg;
        bit        typed;
        t_out      rsp;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    t_in         i_req = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    t_out        o_rsp;
    logic        i_cfg_we = 1'b0;
    logic [6:0]  i_cfg_wdata = '0;

    // predictor state
    logic [CAP_BITS-1:0] cap_mat [MAX_NODES][MAX_NODES];
    longint unsigned     resid [MAX_NODES][MAX_NODES];
    int                  parent [MAX_NODES];
    bit                  seen [MAX_NODES];
    int                  bfs_q [MAX_NODES];
    logic [6:0]          node_cnt;

    t_out   flow_q[$];
    int     errors = 0;
    int     items = 0;
    int     cycles = 0;
    bit     no_idle = 1'b0;
    t_row   dir_rows[$];

    max_flow_bfs_augment_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_req      (i_req),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_rsp      (o_rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("** max_flow_bfs_augment_core: FAILED **");
            $finish;
        end
    end

    function automatic bit find_path(int n);
        int head, tail, x;
        head = 0;
        tail = 0;
        for (int i = 0; i < MAX_NODES; i++) seen[i] = 1'b0;
        seen[0] = 1'b1;
        bfs_q[tail++] = 0;
        while (head < tail) begin
            x = bfs_q[head++];
            for (int v = 0; v < n; v++) begin
                if (!seen[v] && resid[x][v] > 0) begin
                    seen[v] = 1'b1;
                    parent[v] = x;
                    if (v == n - 1) return 1'b1;
                    if (tail < MAX_NODES) bfs_q[tail++] = v;
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic t_out solve_flow();
        int n, v, u;
        longint unsigned total, neck;
        int paths;
        t_out r;
        n = node_cnt;
        if (n < 2) n = 2;
        if (n > MAX_NODES) n = MAX_NODES;
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++) resid[i][j] = cap_mat[i][j];
        total = 0;
        paths = 0;
        while (find_path(n)) begin
            v = n - 1;
            neck = resid[parent[v]][v];
            while (v != 0) begin
                u = parent[v];
                if (resid[u][v] < neck) neck = resid[u][v];
                v = u;
            end
            v = n - 1;
            while (v != 0) begin
                u = parent[v];
                resid[u][v] -= neck;
                resid[v][u] += neck;
                v = u;
            end
            if (total + neck > longint'(FLOW_MAX)) total = FLOW_MAX;
            else total += neck;
            if (paths < PATH_MAX) paths++;
        end
        r.max_flow = total[FLOW_W-1:0];
        r.path_count = paths[PATH_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("[%0t] mismatch %s: got %0h expected %0h", $time, what, got, want);
        errors++;
    endtask

    // response side: random backpressure and in-order check
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (flow_q.size() == 0) begin
                    report_mismatch("unexpected response", 64'(o_rsp), 64'd0);
                end else begin
                    if (o_rsp.max_flow !== flow_q[0].max_flow)
                        report_mismatch("max_flow", 64'(o_rsp.max_flow),
                                        64'(flow_q[0].max_flow));
                    if (o_rsp.path_count !== flow_q[0].path_count)
                        report_mismatch("path_count", 64'(o_rsp.path_count),
                                        64'(flow_q[0].path_count));
                    void'(flow_q.pop_front());
                end
            end
            i_ready <= no_idle || ($urandom_range(0, 99) >= 16);
        end
    end

    // drive one request; valid holds until the edge where ready is seen
    task automatic send_req(t_in r, bit typed, t_out want);
        t_out p;
        if (!no_idle && $urandom_range(0, 99) < 16) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (!o_ready);
        items++;
        if (r.req_type == REQ_WRITE) begin
            cap_mat[r.from_node][r.to_node] = r.capacity;
        end else begin
            p = solve_flow();
            flow_q.insert(flow_q.size(), typed ? want : p);
        end
    endtask

    task automatic write_node_count(logic [6:0] val);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (flow_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        node_cnt = val;
    endtask

    function automatic t_in edge_req(int a, int b, logic [31:0] c);
        t_in r;
        r.req_type = REQ_WRITE;
        r.from_node = a[NODE_W-1:0];
        r.to_node = b[NODE_W-1:0];
        r.capacity = c;
        return r;
    endfunction

    function automatic t_in compute_req();
        t_in r;
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        r = t_in'(bits[$bits(t_in)-1:0]);
        r.req_type = REQ_COMPUTE;
        return r;
    endfunction

    function automatic void add_row(t_row_kind k, t_in r, logic [6:0] c, bit typed,
                                    logic [39:0] f, logic [15:0] pc);
        t_row row;
        row.kind = k;
        row.req = r;
        row.cfg = c;
        row.typed = typed;
        row.rsp.max_flow = f;
        row.rsp.path_count = pc;
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    initial begin
        t_in  r;
        t_out none;
        int   n_hi, k, sel, graph;
        logic [31:0] cval;

        none = '0;
        for (int i = 0; i < MAX_NODES; i++)
            for (int j = 0; j < MAX_NODES; j++) cap_mat[i][j] = '0;
        node_cnt = 7'd64;

        // empty graph, full width edge, self loop, clamped node counts, unused fields
        add_row(ROW_REQ, compute_req(), 0, 1, 40'd0, 16'd0);
        add_row(ROW_REQ, edge_req(0, 63, 32'hFFFF_FFFF), 0, 0, 0, 0);
        add_row(ROW_REQ, edge_req(63, 63, 32'd5), 0, 0, 0, 0);
        add_row(ROW_REQ, compute_req(), 0, 1, 40'hFFFF_FFFF, 16'd1);
        add_row(ROW_CFG, '0, 7'd0, 0, 0, 0);
        add_row(ROW_REQ, edge_req(0, 1, 32'd7), 0, 0, 0, 0);
        add_row(ROW_REQ, compute_req(), 0, 1, 40'd7, 16'd1);
        add_row(ROW_CFG, '0, 7'd127, 0, 0, 0);
        add_row(ROW_REQ, edge_req(0, 1, 32'd0), 0, 0, 0, 0);
        add_row(ROW_REQ, edge_req(1, 63, 32'd3), 0, 0, 0, 0);
        add_row(ROW_REQ, edge_req(0, 2, 32'hFFFF_FFFF), 0, 0, 0, 0);
        add_row(ROW_REQ, edge_req(2, 63, 32'hFFFF_FFFF), 0, 0, 0, 0);
        add_row(ROW_REQ, compute_req(), 0, 1, 40'h1_FFFF_FFFE, 16'd2);
        add_row(ROW_REQ, t_in'({1'b1, 6'h3F, 6'h3F, 32'hFFFF_FFFF}), 0, 1,
                40'h1_FFFF_FFFE, 16'd2);
        add_row(ROW_CFG, '0, 7'd3, 0, 0, 0);
        add_row(ROW_REQ, compute_req(), 0, 1, 40'hFFFF_FFFF, 16'd1);
        add_row(ROW_REQ, edge_req(0, 1, 32'd9), 0, 0, 0, 0);
        add_row(ROW_REQ, edge_req(1, 2, 32'd4), 0, 0, 0, 0);
        add_row(ROW_REQ, edge_req(2, 1, 32'd6), 0, 0, 0, 0);
        add_row(ROW_REQ, compute_req(), 0, 0, 0, 0);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG)
                write_node_count(dir_rows[i].cfg);
            else
                send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);
        end

        graph = 0;
        while (items < NUM_ITEMS) begin
            no_idle = (graph >= 40 && graph < 55);
            sel = $urandom_range(0, 29);
            case (sel)
                0: write_node_count(7'd0);
                1: write_node_count(7'd1);
                2: write_node_count(7'd127);
                3: write_node_count(7'd64);
                4, 5, 6: ;  // keep the previous size
                default: write_node_count(7'($urandom_range(2, 12)));
            endcase
            n_hi = (node_cnt < 2) ? 1 : (node_cnt > 12) ? 11 : node_cnt - 1;
            repeat ($urandom_range(1, 2)) begin
                k = $urandom_range(2, 14);
                repeat (k) begin
                    case ($urandom_range(0, 5))
                        0: cval = 32'd0;
                        1: cval = 32'hFFFF_FFFF;
                        2: cval = $urandom;
                        default: cval = $urandom_range(1, 100);
                    endcase
                    if ($urandom_range(0, 99) < 6)
                        r = edge_req($urandom_range(0, 63), $urandom_range(0, 63), cval);
                    else
                        r = edge_req($urandom_range(0, n_hi), $urandom_range(0, n_hi), cval);
                    send_req(r, 0, none);
                end
                send_req(compute_req(), 0, none);
            end
            graph++;
        end
        no_idle = 1'b0;

        i_valid <= 1'b0;
        while (flow_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0)
            $display("** max_flow_bfs_augment_core: PASSED **");
        else
            $display("** max_flow_bfs_augment_core: FAILED **");
        $finish;
    end
endmodule
